### design/assert_macros.svh
// assertion helpers shared by the filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define PF_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// property that must hold in the cycle after a trigger
`define PF_ASSERT_NEXT(name, trig, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) else $error(msg);

`endif

### design/ipv4_pf_pkg.sv
// ============================================================================
// ipv4_pf_pkg
// Shared constants and codes for the IPv4 header packet filter.
// ============================================================================
package ipv4_pf_pkg;

    // frame size limit default
    localparam int MAX_FRAME_BYTES_DEF = 65535;

    // register reset values
    localparam logic [31:0] BLOCKED_SRC_RST = 32'h7B2D_4359;
    localparam logic [15:0] TCP_PASS_RST    = 16'd22;
    localparam logic [15:0] TCP_WATCH_RST   = 16'd21;
    localparam logic [15:0] UDP_PASS_RST    = 16'd53;

    // header offsets and minimum lengths in bytes
    localparam logic [6:0] ETH_HDR_LEN  = 7'd14;
    localparam logic [6:0] IP_MIN_END   = 7'd34;
    localparam logic [6:0] TCP_HDR_LEN  = 7'd20;
    localparam logic [6:0] L4_MIN_LEN   = 7'd8;

    // fixed byte positions in the frame
    localparam logic [4:0] POS_ETYPE_HI = 5'd12;
    localparam logic [4:0] POS_ETYPE_LO = 5'd13;
    localparam logic [4:0] POS_IHL      = 5'd14;
    localparam logic [4:0] POS_PROTO    = 5'd23;
    localparam logic [4:0] POS_SRC_0    = 5'd26;
    localparam logic [4:0] POS_SRC_1    = 5'd27;
    localparam logic [4:0] POS_SRC_2    = 5'd28;
    localparam logic [4:0] POS_SRC_3    = 5'd29;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_BLOCKED_SRC = 2'd0,
        CFG_TCP_PASS    = 2'd1,
        CFG_TCP_WATCH   = 2'd2,
        CFG_UDP_PASS    = 2'd3
    } cfg_index_t;

    // verdict reason codes
    typedef enum logic [2:0] {
        RSN_DEFAULT     = 3'd0,
        RSN_SHORT_ETH   = 3'd1,
        RSN_NOT_IPV4    = 3'd2,
        RSN_SHORT_IP    = 3'd3,
        RSN_BLOCKED_SRC = 3'd4,
        RSN_SHORT_L4    = 3'd5,
        RSN_TCP_PASS    = 3'd6,
        RSN_UDP_PASS    = 3'd7
    } reason_t;

endpackage

### design/ipv4_header_packet_filter.sv
// Path: last beat -> input register -> capture/snapshot -> result register ->
// m_tvalid, each held by back-pressure. Throughput: one byte beat per cycle unless
// a last beat waits on the snapshot, one verdict per frame, set by the byte-wide
// capture stage. Reset: rst_n clears all frame state and loads the register defaults.
// ============================================================================
// ipv4_header_packet_filter
// Byte-serial IPv4 header parser giving a pass/drop verdict per frame.
// ============================================================================
`include "assert_macros.svh"

module ipv4_header_packet_filter
    import ipv4_pf_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // frame byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] frame_byte
    input  logic        s_tlast,    // last_byte
    // verdict stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] drop_frame, [3:1] verdict_reason, [4] watch_port_hit, [5] icmp_seen,
    // [13:6] icmp_type_out, [21:14] icmp_code_out, [23:22] zero
    output logic [23:0] m_tdata,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

    // configuration registers
    logic [31:0] blocked_src_reg;
    logic [15:0] tcp_pass_reg;
    logic [15:0] tcp_watch_reg;
    logic [15:0] udp_pass_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocked_src_reg <= BLOCKED_SRC_RST;
            tcp_pass_reg    <= TCP_PASS_RST;
            tcp_watch_reg   <= TCP_WATCH_RST;
            udp_pass_reg    <= UDP_PASS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BLOCKED_SRC: blocked_src_reg <= cfg_data;
                CFG_TCP_PASS:    tcp_pass_reg    <= cfg_data[15:0];
                CFG_TCP_WATCH:   tcp_watch_reg   <= cfg_data[15:0];
                CFG_UDP_PASS:    udp_pass_reg    <= cfg_data[15:0];
            endcase
        end
    end

    // handshake between stages
    logic in_valid_reg;
    logic [7:0] in_byte_reg;
    logic in_last_reg;
    logic snap_valid_reg;
    logic m_valid_reg;
    logic in_fire;
    logic snap_ready;
    logic out_load;

    assign out_load   = snap_valid_reg && (!m_valid_reg || m_tready);
    assign snap_ready = !snap_valid_reg || out_load;
    assign in_fire    = in_valid_reg && (!in_last_reg || snap_ready);
    assign s_tready   = !in_valid_reg || in_fire;

    // input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // per-frame capture state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0] ether_type_reg, ether_type_next;
    logic [3:0]  header_words_reg, header_words_next;
    logic [7:0]  ip_protocol_reg, ip_protocol_next;
    logic [31:0] source_addr_reg, source_addr_next;
    logic [15:0] dest_port_reg, dest_port_next;
    logic [7:0]  icmp_type_reg, icmp_type_next;
    logic [7:0]  icmp_code_reg, icmp_code_next;
    logic [6:0]  l4_pos;
    logic        capture_en;

    // field capture at fixed and header-length-relative positions
    always_comb
    begin
        pos_next          = pos_reg;
        ether_type_next   = ether_type_reg;
        header_words_next = header_words_reg;
        ip_protocol_next  = ip_protocol_reg;
        source_addr_next  = source_addr_reg;
        dest_port_next    = dest_port_reg;
        icmp_type_next    = icmp_type_reg;
        icmp_code_next    = icmp_code_reg;
        capture_en        = pos_reg < MAX_POS;

        if (capture_en && pos_reg == POS_W'(POS_IHL))
        begin
            header_words_next = in_byte_reg[3:0];
        end
        // l4 offset follows the ihl byte even on the beat that carries it
        l4_pos = ETH_HDR_LEN + {1'b0, header_words_next, 2'b00};

        if (capture_en)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == POS_W'(POS_ETYPE_HI)) ether_type_next[15:8] = in_byte_reg;
            if (pos_reg == POS_W'(POS_ETYPE_LO)) ether_type_next[7:0]  = in_byte_reg;
            if (pos_reg == POS_W'(POS_PROTO))    ip_protocol_next      = in_byte_reg;
            if (pos_reg == POS_W'(POS_SRC_0))    source_addr_next[31:24] = in_byte_reg;
            if (pos_reg == POS_W'(POS_SRC_1))    source_addr_next[23:16] = in_byte_reg;
            if (pos_reg == POS_W'(POS_SRC_2))    source_addr_next[15:8]  = in_byte_reg;
            if (pos_reg == POS_W'(POS_SRC_3))    source_addr_next[7:0]   = in_byte_reg;
            if (pos_reg == POS_W'(l4_pos))         icmp_type_next       = in_byte_reg;
            if (pos_reg == POS_W'(l4_pos + 7'd1))  icmp_code_next       = in_byte_reg;
            if (pos_reg == POS_W'(l4_pos + 7'd2))  dest_port_next[15:8] = in_byte_reg;
            if (pos_reg == POS_W'(l4_pos + 7'd3))  dest_port_next[7:0]  = in_byte_reg;
        end
    end

    // frame state update, cleared after the last beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            ether_type_reg   <= '0;
            header_words_reg <= '0;
            ip_protocol_reg  <= '0;
            source_addr_reg  <= '0;
            dest_port_reg    <= '0;
            icmp_type_reg    <= '0;
            icmp_code_reg    <= '0;
        end
        else if (in_fire)
        begin
            if (in_last_reg)
            begin
                pos_reg          <= '0;
                ether_type_reg   <= '0;
                header_words_reg <= '0;
                ip_protocol_reg  <= '0;
                source_addr_reg  <= '0;
                dest_port_reg    <= '0;
                icmp_type_reg    <= '0;
                icmp_code_reg    <= '0;
            end
            else
            begin
                pos_reg          <= pos_next;
                ether_type_reg   <= ether_type_next;
                header_words_reg <= header_words_next;
                ip_protocol_reg  <= ip_protocol_next;
                source_addr_reg  <= source_addr_next;
                dest_port_reg    <= dest_port_next;
                icmp_type_reg    <= icmp_type_next;
                icmp_code_reg    <= icmp_code_next;
            end
        end
    end

    // end-of-frame snapshot
    logic [POS_W-1:0] snap_len_reg;
    logic [15:0] snap_etype_reg;
    logic [3:0]  snap_words_reg;
    logic [7:0]  snap_proto_reg;
    logic [31:0] snap_src_reg;
    logic [15:0] snap_port_reg;
    logic [7:0]  snap_type_reg;
    logic [7:0]  snap_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (in_fire && in_last_reg)
        begin
            snap_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_last_reg)
        begin
            snap_len_reg   <= pos_next;
            snap_etype_reg <= ether_type_next;
            snap_words_reg <= header_words_next;
            snap_proto_reg <= ip_protocol_next;
            snap_src_reg   <= source_addr_next;
            snap_port_reg  <= dest_port_next;
            snap_type_reg  <= icmp_type_next;
            snap_code_reg  <= icmp_code_next;
        end
    end

    // verdict decision
    logic [6:0] l4_base;
    logic [6:0] tcp_end;
    logic [6:0] l4_min_end;
    logic       drop_next;
    reason_t    reason_next;
    logic       watch_next;
    logic       icmp_next;
    logic [7:0] icmp_type_out_next;
    logic [7:0] icmp_code_out_next;

    always_comb
    begin
        l4_base            = ETH_HDR_LEN + {1'b0, snap_words_reg, 2'b00};
        tcp_end            = l4_base + TCP_HDR_LEN;
        l4_min_end         = l4_base + L4_MIN_LEN;
        drop_next          = 1'b0;
        reason_next        = RSN_DEFAULT;
        watch_next         = 1'b0;
        icmp_next          = 1'b0;
        icmp_type_out_next = '0;
        icmp_code_out_next = '0;

        priority if (snap_len_reg < POS_W'(ETH_HDR_LEN))
        begin
            drop_next   = 1'b1;
            reason_next = RSN_SHORT_ETH;
        end
        else if (snap_etype_reg != ETHERTYPE_IPV4)
        begin
            reason_next = RSN_NOT_IPV4;
        end
        else if (snap_len_reg < POS_W'(IP_MIN_END))
        begin
            drop_next   = 1'b1;
            reason_next = RSN_SHORT_IP;
        end
        else if (snap_src_reg == blocked_src_reg)
        begin
            drop_next   = 1'b1;
            reason_next = RSN_BLOCKED_SRC;
        end
        else if (snap_proto_reg == PROTO_TCP)
        begin
            priority if (snap_len_reg < POS_W'(tcp_end))
            begin
                drop_next   = 1'b1;
                reason_next = RSN_SHORT_L4;
            end
            else if (snap_port_reg == tcp_pass_reg)
            begin
                reason_next = RSN_TCP_PASS;
            end
            else if (snap_port_reg == tcp_watch_reg)
            begin
                watch_next = 1'b1;
            end
            else
            begin
                watch_next = 1'b0;
            end
        end
        else if (snap_proto_reg == PROTO_UDP)
        begin
            priority if (snap_len_reg < POS_W'(l4_min_end))
            begin
                drop_next   = 1'b1;
                reason_next = RSN_SHORT_L4;
            end
            else if (snap_port_reg == udp_pass_reg)
            begin
                reason_next = RSN_UDP_PASS;
            end
            else
            begin
                reason_next = RSN_DEFAULT;
            end
        end
        else if (snap_proto_reg == PROTO_ICMP)
        begin
            if (snap_len_reg < POS_W'(l4_min_end))
            begin
                drop_next   = 1'b1;
                reason_next = RSN_SHORT_L4;
            end
            else
            begin
                icmp_next          = 1'b1;
                icmp_type_out_next = snap_type_reg;
                icmp_code_out_next = snap_code_reg;
            end
        end
        else
        begin
            // other protocols pass by default
            reason_next = RSN_DEFAULT;
        end
    end

    // result register
    logic       drop_reg;
    reason_t    reason_reg;
    logic       watch_reg;
    logic       icmp_reg;
    logic [7:0] icmp_type_out_reg;
    logic [7:0] icmp_code_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            drop_reg          <= drop_next;
            reason_reg        <= reason_next;
            watch_reg         <= watch_next;
            icmp_reg          <= icmp_next;
            icmp_type_out_reg <= icmp_type_out_next;
            icmp_code_out_reg <= icmp_code_out_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, icmp_code_out_reg, icmp_type_out_reg, icmp_reg, watch_reg,
                       reason_reg, drop_reg};

    // checks
    `PF_ASSERT(a_drop_matches_reason, !m_valid_reg || (drop_reg == (reason_reg == RSN_SHORT_ETH
        || reason_reg == RSN_SHORT_IP || reason_reg == RSN_BLOCKED_SRC
        || reason_reg == RSN_SHORT_L4)), "drop flag disagrees with reason")
    `PF_ASSERT(a_flags_default_only, !m_valid_reg || !(watch_reg || icmp_reg)
        || (!drop_reg && reason_reg == RSN_DEFAULT), "watch or icmp flag on non-default verdict")
    `PF_ASSERT(a_icmp_fields_zero, !m_valid_reg || icmp_reg
        || (icmp_type_out_reg == 8'd0 && icmp_code_out_reg == 8'd0), "icmp fields set without icmp")
    `PF_ASSERT_NEXT(a_clear_after_last, in_fire && in_last_reg,
        pos_reg == '0 && header_words_reg == '0, "frame state not cleared after last beat")

endmodule
